// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the checker file of the grid plotter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tgp_pkg.sv =====
// shared types and constants of the turtle grid plotter
package tgp_pkg;

  // default grid size
  localparam int GRID_WIDTH_DEF  = 32;
  localparam int GRID_HEIGHT_DEF = 32;

  // stream payload widths
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 16;

  // command codes carried on in_tuser
  typedef enum logic [2:0] {
    KIND_PEN_UP   = 3'd0,
    KIND_PEN_DOWN = 3'd1,
    KIND_ROT_CW   = 3'd2,
    KIND_ROT_CCW  = 3'd3,
    KIND_MOVE     = 3'd4,
    KIND_CLEAR    = 3'd5,
    KIND_READ     = 3'd6
  } kind_t;

  // heading, turning clockwise counts up
  typedef enum logic [1:0] {
    HEAD_EAST  = 2'd0,
    HEAD_SOUTH = 2'd1,
    HEAD_WEST  = 2'd2,
    HEAD_NORTH = 2'd3
  } head_t;

endpackage

// ===== hw/rtl/tgp_ram.sv =====
// generic single-write, single-read ram with registered read data
module tgp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/tgp_stepper.sv =====
// shared position unit: move range check and single-cell step
module tgp_stepper import tgp_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic [$clog2(GRID_WIDTH)-1:0]  cur_x,
  input  logic [$clog2(GRID_HEIGHT)-1:0] cur_y,
  input  head_t                          head,
  input  logic [4:0]                     move_dist,
  output logic                           fits,
  output logic [$clog2(GRID_WIDTH)-1:0]  step_x,
  output logic [$clog2(GRID_HEIGHT)-1:0] step_y
);

  localparam int CW = $clog2(GRID_WIDTH);
  localparam int RW = $clog2(GRID_HEIGHT);

  logic [6:0] x_ext;
  logic [6:0] y_ext;
  logic [6:0] d_ext;
  logic [6:0] lhs;
  logic [6:0] rhs;

  assign x_ext = 7'(cur_x);
  assign y_ext = 7'(cur_y);
  assign d_ext = 7'(move_dist);

  // one add and one compare, operands picked by heading
  always_comb begin
    case (head)
      HEAD_EAST: begin
        lhs = x_ext + d_ext;
        rhs = 7'(GRID_WIDTH - 1);
      end
      HEAD_SOUTH: begin
        lhs = y_ext + d_ext;
        rhs = 7'(GRID_HEIGHT - 1);
      end
      HEAD_WEST: begin
        lhs = d_ext;
        rhs = x_ext;
      end
      default: begin
        lhs = d_ext;
        rhs = y_ext;
      end
    endcase
  end

  assign fits = (lhs <= rhs);

  // one cell forward along the heading
  always_comb begin
    step_x = cur_x;
    step_y = cur_y;
    case (head)
      HEAD_EAST:  step_x = cur_x + CW'(1);
      HEAD_SOUTH: step_y = cur_y + RW'(1);
      HEAD_WEST:  step_x = cur_x - CW'(1);
      default:    step_y = cur_y - RW'(1);
    endcase
  end

endmodule

// ===== hw/rtl/turtle_grid_plotter.sv =====
// turtle grid plotter top level: command sequencer, turtle state and grid row memory
// results: pen, rotate, clear, unused, zero or rejected moves answer the cycle after accept
// a cell read runs S_CELL then S_DONE; a move runs S_RD and S_WR (read and write) per cell, then S_DONE
// throughput: pen, rotate, clear and zero or rejected moves are taken every cycle while the
// output drains; the grid row memory read-modify-write per cell sets the move rate
// reset: turtle at 0,0 east, pen up; grid rows cleared at once by per-row valid bits
module turtle_grid_plotter import tgp_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input transaction
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // distance[4:0], read_row[9:5], read_col[14:10]
  input  logic [IN_USER_W-1:0]  in_tuser,   // kind[2:0]
  // result transaction
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // pos_x[4:0], pos_y[9:5], heading[11:10],
                                            // pen_down[12], status[13], cell_marked[14]
);

  localparam int CW = $clog2(GRID_WIDTH);
  localparam int RW = $clog2(GRID_HEIGHT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_CELL,
    S_DONE
  } state_t;

  state_t                  st_r, st_nxt;
  logic [CW-1:0]           x_r, x_nxt;
  logic [RW-1:0]           y_r, y_nxt;
  head_t                   head_r, head_nxt;
  logic                    pen_r, pen_nxt;
  logic [4:0]              cnt_r, cnt_nxt;
  logic                    marked_r, marked_nxt;
  logic [RW-1:0]           cell_row_r, cell_row_nxt;
  logic [CW-1:0]           cell_col_r, cell_col_nxt;
  logic                    cell_in_r, cell_in_nxt;
  logic [GRID_HEIGHT-1:0]  vld_r, vld_nxt;
  logic                    out_vld_r, out_vld_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;

  logic [4:0]              in_dist;
  logic [6:0]              in_row_ext;
  logic [6:0]              in_col_ext;
  kind_t                   in_kind;
  logic                    in_acc;
  logic                    out_free;

  logic                    fits;
  logic [CW-1:0]           step_x;
  logic [RW-1:0]           step_y;

  logic                    wr_en;
  logic [RW-1:0]           rd_addr;
  logic [GRID_WIDTH-1:0]   rd_data;
  logic [GRID_WIDTH-1:0]   row_cur;
  logic [GRID_WIDTH-1:0]   wr_data;

  // result packing, position truncated to five bits
  function automatic logic [OUT_DATA_W-1:0] pack_result(
    input logic [CW-1:0] px,
    input logic [RW-1:0] py,
    input head_t         ph,
    input logic          ppen,
    input logic          pstat,
    input logic          pmark
  );
    logic [7:0] x8;
    logic [7:0] y8;
    x8 = 8'(px);
    y8 = 8'(py);
    return {1'b0, pmark, pstat, ppen, ph, y8[4:0], x8[4:0]};
  endfunction

  // input fields
  assign in_kind    = kind_t'(in_tuser);
  assign in_dist    = in_tdata[4:0];
  assign in_row_ext = {2'b00, in_tdata[9:5]};
  assign in_col_ext = {2'b00, in_tdata[14:10]};

  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = (st_r == S_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  tgp_stepper #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_stepper (
    .cur_x     (x_r),
    .cur_y     (y_r),
    .head      (head_r),
    .move_dist (in_dist),
    .fits      (fits),
    .step_x    (step_x),
    .step_y    (step_y)
  );

  // grid held as one word per row
  tgp_ram #(
    .WIDTH (GRID_WIDTH),
    .DEPTH (GRID_HEIGHT)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (y_r),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // a row never written since the last clear reads as empty
  assign row_cur = vld_r[y_r] ? rd_data : '0;
  assign wr_data = row_cur | ({{(GRID_WIDTH-1){1'b0}}, 1'b1} << x_r);

  // row read address for the next cycle
  always_comb begin
    case (st_r)
      S_IDLE:  rd_addr = in_row_ext[RW-1:0];
      S_RD:    rd_addr = step_y;
      default: rd_addr = y_r;
    endcase
  end

  // sequencer next state
  always_comb begin
    st_nxt       = st_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    head_nxt     = head_r;
    pen_nxt      = pen_r;
    cnt_nxt      = cnt_r;
    marked_nxt   = marked_r;
    cell_row_nxt = cell_row_r;
    cell_col_nxt = cell_col_r;
    cell_in_nxt  = cell_in_r;
    vld_nxt      = vld_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    wr_en        = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            KIND_PEN_UP: begin
              pen_nxt      = 1'b0;
              out_vld_nxt  = 1'b1;
              out_data_nxt = pack_result(x_r, y_r, head_r, 1'b0, 1'b0, 1'b0);
            end
            KIND_PEN_DOWN: begin
              pen_nxt      = 1'b1;
              out_vld_nxt  = 1'b1;
              out_data_nxt = pack_result(x_r, y_r, head_r, 1'b1, 1'b0, 1'b0);
            end
            KIND_ROT_CW: begin
              head_nxt     = head_t'(head_r + 2'd1);
              out_vld_nxt  = 1'b1;
              out_data_nxt = pack_result(x_r, y_r, head_nxt, pen_r, 1'b0, 1'b0);
            end
            KIND_ROT_CCW: begin
              head_nxt     = head_t'(head_r - 2'd1);
              out_vld_nxt  = 1'b1;
              out_data_nxt = pack_result(x_r, y_r, head_nxt, pen_r, 1'b0, 1'b0);
            end
            KIND_MOVE: begin
              marked_nxt = 1'b0;
              if (!fits || in_dist == 5'd0) begin
                out_vld_nxt  = 1'b1;
                out_data_nxt = pack_result(x_r, y_r, head_r, pen_r, !fits, 1'b0);
              end else begin
                cnt_nxt = in_dist;
                st_nxt  = S_RD;
              end
            end
            KIND_CLEAR: begin
              x_nxt        = '0;
              y_nxt        = '0;
              head_nxt     = HEAD_EAST;
              pen_nxt      = 1'b0;
              vld_nxt      = '0;
              out_vld_nxt  = 1'b1;
              out_data_nxt = pack_result('0, '0, HEAD_EAST, 1'b0, 1'b0, 1'b0);
            end
            KIND_READ: begin
              cell_row_nxt = in_row_ext[RW-1:0];
              cell_col_nxt = in_col_ext[CW-1:0];
              cell_in_nxt  = (in_row_ext < 7'(GRID_HEIGHT)) &&
                             (in_col_ext < 7'(GRID_WIDTH));
              st_nxt       = S_CELL;
            end
            default: begin
              out_vld_nxt  = 1'b1;
              out_data_nxt = pack_result(x_r, y_r, head_r, pen_r, 1'b0, 1'b0);
            end
          endcase
        end
      end
      // step one cell and fetch its row
      S_RD: begin
        x_nxt  = step_x;
        y_nxt  = step_y;
        st_nxt = S_WR;
      end
      // mark the entered cell when drawing
      S_WR: begin
        wr_en = pen_r;
        if (pen_r) begin
          vld_nxt[y_r] = 1'b1;
        end
        cnt_nxt = cnt_r - 5'd1;
        st_nxt  = (cnt_r == 5'd1) ? S_DONE : S_RD;
      end
      S_CELL: begin
        marked_nxt = cell_in_r && vld_r[cell_row_r] && rd_data[cell_col_r];
        st_nxt     = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = pack_result(x_r, y_r, head_r, pen_r, 1'b0, marked_r);
          st_nxt       = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      x_r       <= '0;
      y_r       <= '0;
      head_r    <= HEAD_EAST;
      pen_r     <= 1'b0;
      cnt_r     <= '0;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      head_r    <= head_nxt;
      pen_r     <= pen_nxt;
      cnt_r     <= cnt_nxt;
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    marked_r   <= marked_nxt;
    cell_row_r <= cell_row_nxt;
    cell_col_r <= cell_col_nxt;
    cell_in_r  <= cell_in_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/tgp_checker.sv =====
// port-level checker of the turtle grid plotter, bound to the top level
`include "assert_macros.svh"

module tgp_checker import tgp_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_USER_W-1:0]  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic in_acc;

  assign in_acc = in_tvalid && in_tready;

  // a command is only taken when its result has room
  `ASSERT_IMP(a_ready_has_room, in_tready, !out_tvalid || out_tready, "ready while output full")

  // clear shows the turtle home, east, pen up in the next cycle
  `ASSERT_NXT(a_clear_home, in_acc && in_tuser == KIND_CLEAR, out_tvalid && out_tdata[12:0] == 13'd0, "clear result wrong")

  // a cell read keeps the input closed while the row is fetched
  `ASSERT_NXT(a_read_busy, in_acc && in_tuser == KIND_READ, !in_tready, "ready during cell read")

  // a result is never both a rejected move and a marked read, and its bit 15 is zero
  `ASSERT_IMP(a_stat_mark, out_tvalid, !(out_tdata[13] && out_tdata[14]) && !out_tdata[15], "bad result flags")

endmodule

bind turtle_grid_plotter tgp_checker u_tgp_checker (.*);

// ===== tb/turtle_grid_plotter_tb.sv =====
// stream testbench for the turtle grid plotter: command stimulus, turtle predictor, result check
module turtle_grid_plotter_tb;
  import tgp_pkg::*;

  localparam int GRID_W = GRID_WIDTH_DEF;
  localparam int GRID_H = GRID_HEIGHT_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;       // longest move is 31 cells
  localparam int HOLDOFF_CYCLES = 400;
  localparam int RANDOM_CMDS = 550;
  // kind code that the block leaves unused
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  typedef struct {
    logic [2:0] kind;
    logic [4:0] distance;
    logic [4:0] read_row;
    logic [4:0] read_col;
    bit         drain_first;  // offered only once every result is back
  } plot_cmd_t;

  typedef struct {
    logic [4:0] pos_x;
    logic [4:0] pos_y;
    head_t      heading;
    logic       pen_down;
    logic       status;
    logic       cell_marked;
  } turtle_res_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // distance[4:0], read_row[9:5], read_col[14:10]
  logic [IN_USER_W-1:0]  in_tuser = '0;   // kind[2:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // pos_x[4:0], pos_y[9:5], heading[11:10],
                                          // pen_down[12], status[13], cell_marked[14]

  plot_cmd_t   cmd_q[$];
  turtle_res_t turtle_exp_q[$];
  int          fail_cnt = 0;
  int          results_seen = 0;
  int          cycle_cnt = 0;

  // predictor state
  logic  sheet [GRID_H][GRID_W];
  int    at_col;
  int    at_row;
  head_t aim;
  logic  pen_on;

  turtle_grid_plotter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // wipe the sheet and park the turtle at the origin
  function automatic void wipe_sheet();
    foreach (sheet[r, c]) sheet[r][c] = 1'b0;
    at_col = 0;
    at_row = 0;
    aim = HEAD_EAST;
    pen_on = 1'b0;
  endfunction

  // apply one command to the predictor and return the turtle it leaves
  function automatic turtle_res_t plot_command(input plot_cmd_t c);
    turtle_res_t r;
    logic [1:0]  turn;
    int          dx;
    int          dy;
    int          i;
    bit          fits;
    r.status = 1'b0;
    r.cell_marked = 1'b0;
    dx = 0;
    dy = 0;
    fits = 1'b0;
    case (c.kind)
      KIND_PEN_UP:   pen_on = 1'b0;
      KIND_PEN_DOWN: pen_on = 1'b1;
      KIND_ROT_CW: begin
        turn = aim + 2'd1;
        aim = head_t'(turn);
      end
      KIND_ROT_CCW: begin
        turn = aim - 2'd1;
        aim = head_t'(turn);
      end
      KIND_MOVE: begin
        // west and north may reach column or row 0 exactly
        case (aim)
          HEAD_EAST: begin
            fits = at_col + int'(c.distance) <= GRID_W - 1;
            dx = 1;
          end
          HEAD_SOUTH: begin
            fits = at_row + int'(c.distance) <= GRID_H - 1;
            dy = 1;
          end
          HEAD_WEST: begin
            fits = int'(c.distance) <= at_col;
            dx = -1;
          end
          default: begin
            fits = int'(c.distance) <= at_row;
            dy = -1;
          end
        endcase
        if (!fits) begin
          r.status = 1'b1;
        end else begin
          // the start cell stays as it is, every entered cell gets ink when the pen is down
          for (i = 0; i < int'(c.distance); i++) begin
            at_col += dx;
            at_row += dy;
            if (pen_on) sheet[at_row][at_col] = 1'b1;
          end
        end
      end
      KIND_CLEAR: wipe_sheet();
      KIND_READ: begin
        if (int'(c.read_row) < GRID_H && int'(c.read_col) < GRID_W)
          r.cell_marked = sheet[c.read_row][c.read_col];
      end
      default: ;
    endcase
    r.pos_x = at_col[4:0];
    r.pos_y = at_row[4:0];
    r.heading = aim;
    r.pen_down = pen_on;
    return r;
  endfunction

  function automatic void add_cmd(input logic [2:0] kind, input int len, input int row,
                                  input int col, input bit drain_first);
    plot_cmd_t c;
    c.kind = kind;
    c.distance = len[4:0];
    c.read_row = row[4:0];
    c.read_col = col[4:0];
    c.drain_first = drain_first;
    cmd_q.push_back(c);
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // command sender: bursts of random length with random gaps between them
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin : cmd_driver
    logic        go;
    turtle_res_t plotted;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
    end else begin
      // a transaction went through: predict it and move on
      if (in_tvalid && in_tready) begin
        plotted = plot_command(cmd_q[0]);
        turtle_exp_q.push_back(plotted);
        void'(cmd_q.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (in_tvalid && !in_tready) begin
        go = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        go = 1'b0;
      end else begin
        go = cmd_q.size() != 0 && !(cmd_q[0].drain_first && turtle_exp_q.size() != 0);
      end
      in_tvalid <= go;
      if (go) begin
        in_tdata <= {1'b0, cmd_q[0].read_col, cmd_q[0].read_row, cmd_q[0].distance};
        in_tuser <= cmd_q[0].kind;
      end
    end
  end

  // result receiver: changing stall modes plus one long hold-off
  int  stall_mode = 0;
  int  mode_left = 0;
  int  holdoff_left = 0;
  bit  holdoff_done = 1'b0;
  bit  toggle = 1'b0;
  always @(posedge clk) begin : res_receiver
    logic rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (holdoff_left > 0) begin
        holdoff_left--;
        rdy = 1'b0;
      end else if (!holdoff_done && results_seen >= 150) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
        rdy = 1'b0;
      end else begin
        if (mode_left <= 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        toggle = ~toggle;
        case (stall_mode)
          0:       rdy = 1'b1;
          1:       rdy = $urandom_range(0, 3) != 0;
          2:       rdy = $urandom_range(0, 3) == 0;
          default: rdy = toggle;
        endcase
      end
      out_tready <= rdy;
    end
  end

  // result monitor: compare each transaction with the oldest expectation
  always @(posedge clk) begin : res_monitor
    turtle_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (turtle_exp_q.size() == 0) begin
        $error("result with no command pending: tdata 0x%04h", out_tdata);
        fail_cnt++;
      end else begin
        want = turtle_exp_q.pop_front();
        check_field("pos_x", want.pos_x, out_tdata[4:0]);
        check_field("pos_y", want.pos_y, out_tdata[9:5]);
        check_field("heading", want.heading, out_tdata[11:10]);
        check_field("pen_down", want.pen_down, out_tdata[12]);
        check_field("status", want.status, out_tdata[13]);
        check_field("cell_marked", want.cell_marked, out_tdata[14]);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int n;
    int pick;
    int step_len;
    wipe_sheet();

    // directed: a full square along the border, exact fits and rejections
    add_cmd(KIND_READ, 0, 31, 31, 0);
    add_cmd(KIND_MOVE, 0, 0, 0, 0);        // zero distance
    add_cmd(KIND_PEN_DOWN, 0, 0, 0, 0);
    add_cmd(KIND_MOVE, 31, 0, 0, 0);       // east edge reached exactly
    add_cmd(KIND_MOVE, 1, 0, 0, 0);        // one past the edge
    add_cmd(KIND_ROT_CW, 0, 0, 0, 0);
    add_cmd(KIND_MOVE, 31, 0, 0, 0);
    add_cmd(KIND_ROT_CW, 0, 0, 0, 0);
    add_cmd(KIND_MOVE, 31, 0, 0, 0);       // back to column 0
    add_cmd(KIND_ROT_CW, 0, 0, 0, 0);
    add_cmd(KIND_MOVE, 31, 0, 0, 0);       // back to row 0, origin gets ink
    add_cmd(KIND_MOVE, 1, 0, 0, 0);
    add_cmd(KIND_ROT_CW, 0, 0, 0, 0);      // north wraps to east
    add_cmd(KIND_ROT_CCW, 0, 0, 0, 0);     // east wraps to north
    add_cmd(KIND_READ, 0, 0, 0, 0);
    add_cmd(KIND_READ, 0, 31, 31, 0);
    add_cmd(KIND_READ, 0, 15, 15, 0);
    add_cmd(KIND_UNUSED, 31, 31, 31, 0);
    add_cmd(KIND_PEN_UP, 0, 0, 0, 0);
    add_cmd(KIND_ROT_CW, 0, 0, 0, 0);
    add_cmd(KIND_MOVE, 5, 0, 0, 0);        // pen up leaves no ink
    add_cmd(KIND_READ, 0, 0, 3, 0);
    add_cmd(KIND_CLEAR, 0, 0, 0, 1);
    add_cmd(KIND_READ, 0, 0, 31, 0);
    add_cmd(KIND_MOVE, 31, 0, 0, 0);

    // random: mostly inked moves and reads, a few clears and unused kinds
    n = 0;
    while (n < RANDOM_CMDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        case ($urandom_range(0, 5))
          0, 1, 2: step_len = $urandom_range(0, 7);
          3, 4:    step_len = $urandom_range(8, 20);
          default: step_len = $urandom_range(0, 31);
        endcase
        add_cmd(KIND_MOVE, step_len, $urandom_range(0, 31), $urandom_range(0, 31),
                n % 150 == 75);
      end else if (pick < 62) begin
        add_cmd(KIND_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                $urandom_range(0, 31), 0);
      end else if (pick < 72) begin
        add_cmd(KIND_ROT_CW, $urandom_range(0, 31), 0, 0, 0);
      end else if (pick < 82) begin
        add_cmd(KIND_ROT_CCW, $urandom_range(0, 31), 0, 0, 0);
      end else if (pick < 89) begin
        add_cmd(KIND_PEN_DOWN, 0, $urandom_range(0, 31), 0, 0);
      end else if (pick < 94) begin
        add_cmd(KIND_PEN_UP, 0, 0, $urandom_range(0, 31), 0);
      end else if (pick < 96) begin
        add_cmd(KIND_CLEAR, $urandom_range(0, 31), 0, 0, 0);
      end else begin
        add_cmd(KIND_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
                $urandom_range(0, 31), 0);
        n--;  // ignored commands do not count
      end
      n++;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || turtle_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
